// ===== hw/rtl/hfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfr_pkg: shared types and constants for the ASCII hex frame receiver
// Item kinds, verdict codes, result record and hex digit helpers.
// ----------------------------------------------------------------------------
package hfr_pkg;

  localparam int MAX_CHARS_DEFAULT = 200;
  localparam logic [15:0] TIMEOUT_RESET = 16'd200;

  localparam logic [7:0] START_CHAR = 8'h7E;
  localparam logic [7:0] END_CHAR   = 8'h0D;
  localparam logic [7:0] DIGIT_NINE = 8'h39;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] LETTER_OFS = 8'd9;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_TICK = 2'd1,
    KIND_ARM  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CHECKSUM = 2'd1,
    STATUS_TOO_LONG = 2'd2,
    STATUS_TIMEOUT  = 2'd3
  } status_t;

  typedef struct packed {
    logic       is_verdict;
    logic [7:0] byte_value;
    logic [6:0] byte_index;
    logic [1:0] status;
    logic [7:0] char_count;
  } result_t;

  // Digit value of one character, full 8 bits (wraps below '0').
  function automatic logic [7:0] nibble_of(input logic [7:0] c);
    if (c <= DIGIT_NINE) begin
      return c - DIGIT_ZERO;
    end
    return {5'd0, c[2:0]} + LETTER_OFS;
  endfunction

  function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] nh;
    nh = nibble_of(hi);
    return {nh[3:0], 4'h0} + nibble_of(lo);
  endfunction

endpackage

// ===== hw/rtl/hfr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfr_if: channel interfaces of the ASCII hex frame receiver
// Input item stream, result stream and configuration write channel.
// ----------------------------------------------------------------------------
interface hfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] rx_char;

  modport source (output valid, output kind, output rx_char, input ready);
  modport sink (input valid, input kind, input rx_char, output ready);
endinterface

interface hfr_out_if;
  logic       valid;
  logic       ready;
  logic       is_verdict;
  logic [7:0] byte_value;
  logic [6:0] byte_index;
  logic [1:0] status;
  logic [7:0] char_count;

  modport source (output valid, output is_verdict, output byte_value, output byte_index,
                  output status, output char_count, input ready);
  modport sink (input valid, input is_verdict, input byte_value, input byte_index,
                input status, input char_count, output ready);
endinterface

interface hfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ascii_hex_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_hex_frame_receiver_unit: ASCII hex serial frame receiver
// Hunts for a framed reply, decodes hex byte pairs and checks the checksum.
// ----------------------------------------------------------------------------
// Usage:
//   chars   - input items: kind (character, millisecond tick, arm) and rx_char.
//   results - result items: a decoded body byte with its index, or a verdict
//             (ok, checksum error, too long, timeout) with the body count.
//   cfg     - write of timeout_ticks; always ready, write only while idle.
// Each item is captured in an input register, decoded by the frame core
// and, when it causes a result, loaded into the result register. One
// item is taken every cycle, bounded only by the result register draining.
// When the result consumer stalls, the result register holds its item and
// the input register holds the next one; chars.ready drops only while both
// are full. Items that cause no result pass through without waiting on the
// consumer only if the result register is free.
// Reset clears the window (not armed, no frame open), empties both registers
// and sets timeout_ticks to 200.
// ----------------------------------------------------------------------------
module ascii_hex_frame_receiver_unit #(
  parameter int MAX_CHARS = hfr_pkg::MAX_CHARS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  hfr_in_if.sink    chars,
  hfr_out_if.source results,
  hfr_cfg_if.sink   cfg
);

  logic             in_valid;
  logic [1:0]       in_kind;
  logic [7:0]       in_char;
  logic [15:0]      timeout_ticks;
  logic             out_free;
  logic             advance;
  logic             res_valid;
  hfr_pkg::result_t res;

  assign advance     = in_valid && out_free;
  assign chars.ready = !in_valid || advance;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  // hold the payload while the item waits
  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      in_kind <= chars.kind;
      in_char <= chars.rx_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= hfr_pkg::TIMEOUT_RESET;
    end else if (cfg.valid) begin
      timeout_ticks <= cfg.data;
    end
  end

  hfr_core #(
    .MAX_CHARS(MAX_CHARS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .kind         (in_kind),
    .rx_char      (in_char),
    .timeout_ticks(timeout_ticks),
    .res_valid    (res_valid),
    .res          (res)
  );

  hfr_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && res_valid),
    .res    (res),
    .free   (out_free),
    .results(results)
  );

endmodule

// ===== hw/rtl/hfr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfr_core: frame state and per-item decode
// Holds the reply window state and works out the result of one item.
// ----------------------------------------------------------------------------
module hfr_core #(
  parameter int MAX_CHARS = hfr_pkg::MAX_CHARS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [1:0]       kind,
  input  logic [7:0]       rx_char,
  input  logic [15:0]      timeout_ticks,
  output logic             res_valid,
  output hfr_pkg::result_t res
);

  localparam logic [7:0] MaxCount = 8'(MAX_CHARS);

  logic        armed, armed_next;
  logic        in_frame, in_frame_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  body_count, body_count_next;
  // sum of body characters that have left the last-four window
  logic [15:0] older_sum, older_sum_next;
  logic [31:0] last_four, last_four_next;
  logic [7:0]  high_char, high_char_next;

  logic [7:0]  count_inc;
  logic [15:0] remote_sum;
  logic [15:0] local_sum;

  assign count_inc  = body_count + 8'd1;
  assign remote_sum = {hfr_pkg::hex_pair(last_four[31:24], last_four[23:16]),
                       hfr_pkg::hex_pair(last_four[15:8], last_four[7:0])};
  assign local_sum  = 16'd0 - older_sum;

  always_comb begin
    armed_next      = armed;
    in_frame_next   = in_frame;
    tick_count_next = tick_count;
    body_count_next = body_count;
    older_sum_next  = older_sum;
    last_four_next  = last_four;
    high_char_next  = high_char;
    res_valid       = 1'b0;
    res             = '0;

    case (kind)
      hfr_pkg::KIND_ARM: begin
        armed_next      = 1'b1;
        in_frame_next   = 1'b0;
        tick_count_next = '0;
        body_count_next = '0;
        older_sum_next  = '0;
        last_four_next  = '0;
        high_char_next  = '0;
      end
      hfr_pkg::KIND_TICK: begin
        if (armed) begin
          if (tick_count >= timeout_ticks) begin
            res_valid      = 1'b1;
            res.is_verdict = 1'b1;
            res.status     = hfr_pkg::STATUS_TIMEOUT;
            res.char_count = body_count;
            armed_next     = 1'b0;
            in_frame_next  = 1'b0;
          end else begin
            tick_count_next = tick_count + 16'd1;
          end
        end
      end
      hfr_pkg::KIND_CHAR: begin
        if (armed) begin
          if (!in_frame) begin
            if (rx_char == hfr_pkg::START_CHAR) begin
              in_frame_next = 1'b1;
            end
          end else if (rx_char == hfr_pkg::END_CHAR) begin
            res_valid      = 1'b1;
            res.is_verdict = 1'b1;
            res.char_count = body_count;
            if (body_count >= 8'd4 && local_sum == remote_sum) begin
              res.status = hfr_pkg::STATUS_OK;
            end else begin
              res.status = hfr_pkg::STATUS_CHECKSUM;
            end
            armed_next    = 1'b0;
            in_frame_next = 1'b0;
          end else begin
            older_sum_next  = older_sum + {8'd0, last_four[31:24]};
            last_four_next  = {last_four[23:0], rx_char};
            body_count_next = count_inc;
            if (count_inc >= MaxCount) begin
              res_valid      = 1'b1;
              res.is_verdict = 1'b1;
              res.status     = hfr_pkg::STATUS_TOO_LONG;
              res.char_count = count_inc;
              armed_next     = 1'b0;
              in_frame_next  = 1'b0;
            end else if (!count_inc[0]) begin
              res_valid      = 1'b1;
              res.byte_value = hfr_pkg::hex_pair(high_char, rx_char);
              res.byte_index = count_inc[7:1] - 7'd1;
            end else begin
              high_char_next = rx_char;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed      <= 1'b0;
      in_frame   <= 1'b0;
      tick_count <= '0;
      body_count <= '0;
      older_sum  <= '0;
      last_four  <= '0;
      high_char  <= '0;
    end else if (step) begin
      armed      <= armed_next;
      in_frame   <= in_frame_next;
      tick_count <= tick_count_next;
      body_count <= body_count_next;
      older_sum  <= older_sum_next;
      last_four  <= last_four_next;
      high_char  <= high_char_next;
    end
  end

endmodule

// ===== hw/rtl/hfr_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfr_out_stage: result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module hfr_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  hfr_pkg::result_t res,
  output logic             free,
  hfr_out_if.source        results
);

  logic             valid;
  hfr_pkg::result_t data;

  assign free = !valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (results.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign results.valid      = valid;
  assign results.is_verdict = data.is_verdict;
  assign results.byte_value = data.byte_value;
  assign results.byte_index = data.byte_index;
  assign results.status     = data.status;
  assign results.char_count = data.char_count;

endmodule
